@@ rtl/core/kfc_pkg.sv @@
`timescale 1ns / 1ps

package kfc_pkg;

    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 17;
    localparam int DEN_W   = DATA_W + 1;
    localparam int MUL_A_W = DATA_W + 2;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ESTIMATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 2'd3;

    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE      = 32'd66;
    localparam logic [DATA_W-1:0] RST_MEASURE_NOISE      = 32'd151257088;
    localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE   = 32'd10485760;
    localparam logic [DATA_W-1:0] RST_INITIAL_COVARIANCE = 32'd655;

    localparam logic [DATA_W-1:0] U32_MAX = '1;

endpackage

@@ rtl/core/kfc_in_if.sv @@
`timescale 1ns / 1ps

interface kfc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [kfc_pkg::DATA_W-1:0]   measurement;
    logic                                restart;

    modport source (output valid, output measurement, output restart, input ready);
    modport sink   (input valid, input measurement, input restart, output ready);
endinterface

@@ rtl/core/kfc_out_if.sv @@
`timescale 1ns / 1ps

interface kfc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kfc_pkg::DATA_W-1:0]   estimate;
    logic        [kfc_pkg::DATA_W-1:0]   covariance;
    logic        [kfc_pkg::GAIN_W-1:0]   gain;

    modport source (output valid, output estimate, output covariance, output gain,
                    input ready);
    modport sink   (input valid, input estimate, input covariance, input gain,
                    output ready);
endinterface

@@ rtl/core/kfc_div.sv @@
`timescale 1ns / 1ps

// Restoring divider: quotient = floor(num * 2^16 / (num + add)), one bit a cycle.
module kfc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kfc_pkg::DATA_W-1:0]    i_num,
    input  logic [kfc_pkg::DATA_W-1:0]    i_add,
    output logic                          o_done,
    output logic [kfc_pkg::GAIN_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(kfc_pkg::GAIN_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(kfc_pkg::GAIN_W - 1);

    logic [kfc_pkg::DEN_W-1:0]   r_den;
    logic [kfc_pkg::DEN_W:0]     r_rem;
    logic [kfc_pkg::GAIN_W-1:0]  r_quot;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [kfc_pkg::DEN_W+1:0]   trial;
    logic                        ge;
    logic [kfc_pkg::DEN_W-1:0]   rem_sel;

    always_comb begin
        trial   = {1'b0, r_rem} - {2'b00, r_den};
        ge      = !trial[kfc_pkg::DEN_W+1];
        rem_sel = ge ? trial[kfc_pkg::DEN_W-1:0] : r_rem[kfc_pkg::DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= {1'b0, i_num} + {1'b0, i_add};
                r_rem  <= {2'b00, i_num};
                r_quot <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= {rem_sel, 1'b0};
                r_quot <= {r_quot[kfc_pkg::GAIN_W-2:0], ge};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    // zero denominator: gain of one
    assign o_quot = (r_den == '0) ? kfc_pkg::GAIN_ONE : r_quot;

endmodule

@@ rtl/core/kfc_mul.sv @@
`timescale 1ns / 1ps

// Shared signed multiplier, registered product.
module kfc_mul (
    input  logic                                i_clk,
    input  logic signed [kfc_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [kfc_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [kfc_pkg::PROD_W-1:0]   o_prod
);

    logic signed [kfc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= kfc_pkg::PROD_W'(i_a) * kfc_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/scalar_kalman_filter_core.sv @@
`timescale 1ns / 1ps

// Scalar Kalman filter, constant-state model, Q16.16 fixed point.
// Input channel i_in (valid/ready): one measurement word plus a restart flag;
// restart reloads the initial estimate and covariance before the word is used.
// Output channel o_out (valid/ready): updated estimate, covariance and the
// Q1.16 gain used, exactly one result word per input word.
// One word at a time: i_in.ready is high only while the core is idle. A word
// passes through prediction, the bit-serial gain divider and then two passes
// through one shared multiplier before the result is registered for o_out.
// The result sits in an output register; the next word is accepted while it
// waits, and that word stalls at its last step until the register is freed.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) writes Q, R, the initial
// estimate and the initial covariance; write only while idle.
// Reset (i_rst_n low, synchronous) restores register defaults, loads the
// estimate and covariance from those defaults and empties the output.
module scalar_kalman_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kfc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kfc_pkg::DATA_W-1:0]        i_cfg_data,
    kfc_in_if.sink                            i_in,
    kfc_out_if.source                         o_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_PRED, S_DIV_GO, S_DIV_WAIT, S_MUL_X, S_MUL_P, S_UPD, S_OUT
    } t_state;

    t_state r_state;

    logic [kfc_pkg::DATA_W-1:0]         r_q, r_r, r_init_est, r_init_cov;
    logic signed [kfc_pkg::DATA_W-1:0]  r_est;
    logic [kfc_pkg::DATA_W-1:0]         r_cov;
    logic signed [kfc_pkg::DATA_W-1:0]  r_meas;
    logic [kfc_pkg::DATA_W-1:0]         r_pmid;
    logic signed [kfc_pkg::DATA_W:0]    r_diff;
    logic [kfc_pkg::GAIN_W-1:0]         r_gain;

    logic                               r_out_valid;
    logic signed [kfc_pkg::DATA_W-1:0]  r_out_est;
    logic [kfc_pkg::DATA_W-1:0]         r_out_cov;
    logic [kfc_pkg::GAIN_W-1:0]         r_out_gain;

    logic                               div_start, div_done;
    logic [kfc_pkg::GAIN_W-1:0]         div_quot;
    logic signed [kfc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [kfc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [kfc_pkg::PROD_W-1:0]  mul_prod;

    logic [kfc_pkg::DATA_W:0]           p_sum;
    logic [kfc_pkg::DATA_W-1:0]         n_pmid;
    logic signed [kfc_pkg::PROD_W-1:0]  prod_rnd;
    logic signed [kfc_pkg::DATA_W+4:0]  x_sum;
    logic signed [kfc_pkg::DATA_W-1:0]  n_est;
    logic                               out_free;

    kfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pmid),
        .i_add   (r_r),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    kfc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    always_comb begin
        div_start = (r_state == S_DIV_GO);
        if (r_state == S_MUL_X) begin
            mul_a = {r_diff[kfc_pkg::DATA_W], r_diff};
            mul_b = {1'b0, r_gain};
        end else begin
            mul_a = {2'b00, r_pmid};
            mul_b = {1'b0, kfc_pkg::GAIN_ONE - r_gain};
        end

        p_sum  = {1'b0, r_cov} + {1'b0, r_q};
        n_pmid = p_sum[kfc_pkg::DATA_W] ? kfc_pkg::U32_MAX : p_sum[kfc_pkg::DATA_W-1:0];

        prod_rnd = mul_prod + kfc_pkg::ROUND_HALF;
        // floor shift of the rounded correction, added to the old estimate
        x_sum = (kfc_pkg::DATA_W+5)'(r_est)
              + (kfc_pkg::DATA_W+5)'($signed(prod_rnd[kfc_pkg::PROD_W-1:kfc_pkg::FRAC_W]));
        if (x_sum[kfc_pkg::DATA_W+4:kfc_pkg::DATA_W-1] == '0
            || x_sum[kfc_pkg::DATA_W+4:kfc_pkg::DATA_W-1] == '1) begin
            n_est = x_sum[kfc_pkg::DATA_W-1:0];
        end else if (x_sum[kfc_pkg::DATA_W+4]) begin
            n_est = {1'b1, {(kfc_pkg::DATA_W-1){1'b0}}};
        end else begin
            n_est = {1'b0, {(kfc_pkg::DATA_W-1){1'b1}}};
        end

        out_free = !r_out_valid || o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q         <= kfc_pkg::RST_PROCESS_NOISE;
            r_r         <= kfc_pkg::RST_MEASURE_NOISE;
            r_init_est  <= kfc_pkg::RST_INITIAL_ESTIMATE;
            r_init_cov  <= kfc_pkg::RST_INITIAL_COVARIANCE;
            r_est       <= kfc_pkg::RST_INITIAL_ESTIMATE;
            r_cov       <= kfc_pkg::RST_INITIAL_COVARIANCE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kfc_pkg::CFG_PROCESS_NOISE:      r_q        <= i_cfg_data;
                    kfc_pkg::CFG_MEASURE_NOISE:      r_r        <= i_cfg_data;
                    kfc_pkg::CFG_INITIAL_ESTIMATE:   r_init_est <= i_cfg_data;
                    kfc_pkg::CFG_INITIAL_COVARIANCE: r_init_cov <= i_cfg_data;
                    default: ;
                endcase
            end

            // in S_OUT the reload below handles the handoff
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_meas <= i_in.measurement;
                        if (i_in.restart) begin
                            r_est <= r_init_est;
                            r_cov <= r_init_cov;
                        end
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_pmid  <= n_pmid;
                    r_diff  <= (kfc_pkg::DATA_W+1)'(r_meas) - (kfc_pkg::DATA_W+1)'(r_est);
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_gain  <= div_quot;
                        r_state <= S_MUL_X;
                    end
                end
                S_MUL_X: begin
                    r_state <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_est   <= n_est;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    // product <= p_mid * 2^16, so the rounded result fits
                    r_cov   <= prod_rnd[kfc_pkg::FRAC_W+kfc_pkg::DATA_W-1:kfc_pkg::FRAC_W];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_est   <= r_est;
                        r_out_cov   <= r_cov;
                        r_out_gain  <= r_gain;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.estimate   = r_out_est;
    assign o_out.covariance = r_out_cov;
    assign o_out.gain       = r_out_gain;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam logic signed [kfc_pkg::DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [kfc_pkg::DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam int RAND_PHASES     = 9;
    localparam int WORDS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 40;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic signed [kfc_pkg::DATA_W-1:0] estimate;
        logic        [kfc_pkg::DATA_W-1:0] covariance;
        logic        [kfc_pkg::GAIN_W-1:0] gain;
    } t_kf_result;

    // Tracks Q, R, the reload values and the filter state, and queues the
    // expected estimate/covariance/gain for every word the core takes.
    class kalman_predictor;
        logic        [kfc_pkg::DATA_W-1:0] q_noise;
        logic        [kfc_pkg::DATA_W-1:0] r_noise;
        logic signed [kfc_pkg::DATA_W-1:0] x_init;
        logic        [kfc_pkg::DATA_W-1:0] p_init;
        logic signed [kfc_pkg::DATA_W-1:0] x_state;
        logic        [kfc_pkg::DATA_W-1:0] p_state;
        t_kf_result                        expected_q[$];
        int                                mismatches;

        function new();
            mismatches = 0;
            reset_all();
        endfunction

        function void reset_all();
            q_noise = 32'd66;
            r_noise = 32'd151257088;
            x_init  = 32'sd10485760;
            p_init  = 32'd655;
            x_state = x_init;
            p_state = p_init;
            expected_q.delete();
        endfunction

        function void set_reg(logic [kfc_pkg::CFG_IDX_W-1:0] idx,
                              logic [kfc_pkg::DATA_W-1:0] val);
            case (idx)
                kfc_pkg::CFG_PROCESS_NOISE:      q_noise = val;
                kfc_pkg::CFG_MEASURE_NOISE:      r_noise = val;
                kfc_pkg::CFG_INITIAL_ESTIMATE:   x_init  = val;
                kfc_pkg::CFG_INITIAL_COVARIANCE: p_init  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_sample(logic signed [kfc_pkg::DATA_W-1:0] meas, logic restart);
            longint unsigned p_mid;
            longint unsigned denom;
            longint unsigned k;
            longint unsigned p_next;
            longint          x_prev;
            longint          delta;
            longint          x_next;
            t_kf_result      res;
            if (restart) begin
                x_state = x_init;
                p_state = p_init;
            end
            p_mid = 64'(p_state) + 64'(q_noise);
            if (p_mid > 64'hFFFF_FFFF) p_mid = 64'hFFFF_FFFF;
            denom = p_mid + 64'(r_noise);
            // both P+Q and R zero: gain of one
            k = (denom == 0) ? 64'd65536 : (p_mid << 16) / denom;
            if (k > 64'd65536) k = 64'd65536;
            x_prev = longint'(x_state);
            delta  = longint'(meas) - x_prev;
            x_next = x_prev + ((delta * longint'(k) + 64'sd32768) >>> 16);
            if (x_next > longint'(S32_MAX)) x_next = longint'(S32_MAX);
            if (x_next < longint'(S32_MIN)) x_next = longint'(S32_MIN);
            p_next = (p_mid * (64'd65536 - k) + 64'd32768) >> 16;
            if (p_next > 64'hFFFF_FFFF) p_next = 64'hFFFF_FFFF;
            x_state = x_next[kfc_pkg::DATA_W-1:0];
            p_state = p_next[kfc_pkg::DATA_W-1:0];
            res.estimate   = x_state;
            res.covariance = p_state;
            res.gain       = k[kfc_pkg::GAIN_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic signed [kfc_pkg::DATA_W-1:0] est,
                                   logic [kfc_pkg::DATA_W-1:0] cov,
                                   logic [kfc_pkg::GAIN_W-1:0] g);
            t_kf_result exp_res;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result word est=%0d cov=%0d gain=%0d",
                             $realtime, est, cov, g);
                return;
            end
            exp_res = expected_q.pop_front();
            if (est !== exp_res.estimate || cov !== exp_res.covariance ||
                g !== exp_res.gain) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: mismatch exp est=%0d cov=%0d gain=%0d, ",
                              "got est=%0d cov=%0d gain=%0d"},
                             $realtime, exp_res.estimate, exp_res.covariance, exp_res.gain,
                             est, cov, g);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [kfc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [kfc_pkg::DATA_W-1:0]    cfg_data;
    int                            src_idle_pct;
    int                            sink_idle_pct;
    kalman_predictor               pred;

    kfc_in_if  in_ch ();
    kfc_out_if out_ch ();

    scalar_kalman_filter_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Output side: take result words with random back-pressure.
    initial begin
        out_ch.ready <= 1'b0;
        forever @(posedge clk) begin
            if (rst_n && out_ch.valid && out_ch.ready)
                pred.check_result(out_ch.estimate, out_ch.covariance, out_ch.gain);
            out_ch.ready <= (sink_idle_pct == 0) ||
                            ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic send_word(logic signed [kfc_pkg::DATA_W-1:0] meas, logic restart);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.measurement <= meas;
        in_ch.restart     <= restart;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pred.note_sample(meas, restart);
    endtask

    // Drops valid and waits until every expected word has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pred.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [kfc_pkg::CFG_IDX_W-1:0] idx,
                             logic [kfc_pkg::DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        pred.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_config(logic [kfc_pkg::DATA_W-1:0] q, logic [kfc_pkg::DATA_W-1:0] r,
                               logic [kfc_pkg::DATA_W-1:0] x0,
                               logic [kfc_pkg::DATA_W-1:0] p0);
        write_reg(kfc_pkg::CFG_PROCESS_NOISE, q);
        write_reg(kfc_pkg::CFG_MEASURE_NOISE, r);
        write_reg(kfc_pkg::CFG_INITIAL_ESTIMATE, x0);
        write_reg(kfc_pkg::CFG_INITIAL_COVARIANCE, p0);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [kfc_pkg::DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return kfc_pkg::U32_MAX;
            2:       return $urandom_range(0, 255);
            3:       return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [kfc_pkg::DATA_W-1:0] pick_measurement(
            logic signed [kfc_pkg::DATA_W-1:0] center);
        case ($urandom_range(0, 9))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2, 3:    return $urandom();
            default: return center + (int'($urandom_range(0, 2_000_000)) - 1_000_000);
        endcase
    endfunction

    initial begin
        pred          = new();
        src_idle_pct  = 33;
        sink_idle_pct = 54;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= kfc_pkg::CFG_PROCESS_NOISE;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.measurement <= '0;
        in_ch.restart     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults after reset
        send_word(32'sd0, 1'b0);
        send_word(S32_MAX, 1'b0);
        send_word(S32_MIN, 1'b0);
        send_word(32'sh00A0_0000, 1'b1);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd1, 1'b0);
        wait_drained();

        // zero denominator: P, Q and R all zero, gain of one
        load_config('0, '0, '0, '0);
        send_word(32'sd12345, 1'b1);
        send_word(S32_MIN, 1'b0);
        send_word(S32_MAX, 1'b0);
        wait_drained();

        // P + Q saturates, estimate starts at the positive limit
        load_config(kfc_pkg::U32_MAX, kfc_pkg::U32_MAX, S32_MAX, kfc_pkg::U32_MAX);
        send_word(S32_MIN, 1'b1);
        send_word(S32_MAX, 1'b0);
        send_word(32'sd0, 1'b0);
        wait_drained();

        load_config(kfc_pkg::U32_MAX, '0, S32_MIN, '0);
        send_word(S32_MAX, 1'b1);
        send_word(S32_MIN, 1'b0);
        wait_drained();

        // huge R, zero covariance: gain of zero
        load_config('0, kfc_pkg::U32_MAX, '0, '0);
        send_word(S32_MAX, 1'b1);
        send_word(-32'sd1, 1'b0);
        send_word(S32_MIN, 1'b0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph < RAND_PHASES / 3) begin
                src_idle_pct  = 33;
                sink_idle_pct = 54;
            end else if (ph < 2 * RAND_PHASES / 3) begin
                src_idle_pct  = 54;
                sink_idle_pct = 33;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            load_config(pick_noise(), pick_noise(), $urandom(), pick_noise());
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(pick_measurement(pred.x_state),
                          (n == 0) || ($urandom_range(0, 19) == 0));
            // hold the sender until the core has returned everything
            wait_drained();
        end

        if (pred.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
